// ----- hdl/aept_pkg.sv -----
// Shared types and constants of the absolute encoder position tracker.
`default_nettype none

package aept_pkg;

  localparam int unsigned POSITION_BITS = 24;
  localparam int unsigned MULTI_BITS    = 56;
  localparam int unsigned TURN_BITS     = 32;
  localparam int unsigned ANGLE_BITS    = 16;
  localparam int unsigned SPEED_BITS    = 32;
  localparam int unsigned LOG2_BITS     = 5;
  localparam int unsigned POLE_BITS     = 8;
  localparam int unsigned CFG_ADDR_BITS = 2;

  localparam logic [LOG2_BITS-1:0] K_MIN     = LOG2_BITS'(10);
  localparam logic [LOG2_BITS-1:0] K_MAX     = LOG2_BITS'(POSITION_BITS);
  localparam logic [LOG2_BITS-1:0] K_ANGLE   = LOG2_BITS'(ANGLE_BITS);
  localparam logic [LOG2_BITS-1:0] LOG2_RST  = LOG2_BITS'(14);
  localparam logic [POLE_BITS-1:0] POLES_RST = POLE_BITS'(4);

  // 0.1 rpm per turn per second window scaling
  localparam logic [31:0] SPEED_FACTOR = 32'd1200000;
  localparam logic [56:0] Q_LAST_OK    = 57'd1999;
  localparam int unsigned FILT_OLD     = 38;
  localparam int unsigned FILT_NEW     = 218;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_RES_LOG2 = 2'd0,
    REG_OFFSET   = 2'd1,
    REG_POLES    = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRACK,
    ST_MULTI,
    ST_DIFF,
    ST_ABS,
    ST_SCALE,
    ST_SAT,
    ST_FILT,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic track;
    logic multi;
    logic diff;
    logic absv;
    logic scale;
    logic sat;
    logic filt;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/aept_ctrl.sv -----
// Sequencer for the tracker: walks one sample through the datapath steps.
`default_nettype none

module aept_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire aept_pkg::sts_t sts_i,
  output aept_pkg::cmd_t     cmd_o
);

  aept_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aept_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      aept_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = aept_pkg::ST_TRACK;
        end
      end
      aept_pkg::ST_TRACK: begin
        cmd_o.track = 1'b1;
        state_d     = aept_pkg::ST_MULTI;
      end
      aept_pkg::ST_MULTI: begin
        cmd_o.multi = 1'b1;
        state_d     = sts_i.tick ? aept_pkg::ST_DIFF : aept_pkg::ST_DONE;
      end
      aept_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = aept_pkg::ST_ABS;
      end
      aept_pkg::ST_ABS: begin
        cmd_o.absv = 1'b1;
        state_d    = aept_pkg::ST_SCALE;
      end
      aept_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = aept_pkg::ST_SAT;
      end
      aept_pkg::ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = aept_pkg::ST_FILT;
      end
      aept_pkg::ST_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = aept_pkg::ST_ACC;
      end
      aept_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = aept_pkg::ST_DONE;
      end
      aept_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = aept_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aept_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == aept_pkg::ST_TRACK))
    else $error("accepted beat did not start tracking");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  a_no_tick_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aept_pkg::ST_MULTI && !sts_i.tick) |=> (state_q == aept_pkg::ST_DONE))
    else $error("speed path entered without a tick");

endmodule

`default_nettype wire

// ----- hdl/aept_dp.sv -----
// Datapath: config registers, turn tracking, angle, speed and output register.
`default_nettype none

module aept_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [aept_pkg::POSITION_BITS-1:0]   in_position_i,
  input  wire logic                                 in_speed_tick_i,
  input  wire logic                                 in_turns_reset_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [aept_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  wire logic [aept_pkg::POSITION_BITS-1:0]   cfg_data_i,
  input  wire aept_pkg::cmd_t                       cmd_i,
  output aept_pkg::sts_t                            sts_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [aept_pkg::ANGLE_BITS-1:0]           out_angle_o,
  output logic [aept_pkg::TURN_BITS-1:0]            out_turns_o,
  output logic [aept_pkg::MULTI_BITS-1:0]           out_multi_o,
  output logic [aept_pkg::SPEED_BITS-1:0]           out_speed_o
);

  localparam int unsigned PB = aept_pkg::POSITION_BITS;
  localparam int unsigned MB = aept_pkg::MULTI_BITS;
  localparam int unsigned TB = aept_pkg::TURN_BITS;
  localparam int unsigned SB = aept_pkg::SPEED_BITS;
  localparam int unsigned LB = aept_pkg::LOG2_BITS;

  // config
  logic [LB-1:0]                    log2_q;
  logic [PB-1:0]                    offset_q;
  logic [aept_pkg::POLE_BITS-1:0]   poles_q;

  // tracking state
  logic [PB-1:0] pos_q, last_pos_q;
  logic          tick_q, cmd_q, last_cmd_q;
  logic [TB-1:0] turns_q;
  logic [31:0]   prod_e_q;
  logic [aept_pkg::ANGLE_BITS-1:0] angle_q;
  logic [MB-1:0] multi_q, wsp_q;
  logic [SB-1:0] speed_q;

  // speed pipeline
  logic [MB:0]   diff_q, mag_q;
  logic          neg_q, qsat_q;
  logic [31:0]   prod_q_q;
  logic [44:0]   prod_r_q;
  logic [SB-1:0] raw_q;
  logic signed [37:0] p_old_q;
  logic signed [39:0] p_raw_q;

  // output register
  logic                            out_valid_q;
  logic [aept_pkg::ANGLE_BITS-1:0] out_angle_q;
  logic [TB-1:0]                   out_turns_q;
  logic [MB-1:0]                   out_multi_q;
  logic [SB-1:0]                   out_speed_q;

  // effective exponent and mask
  logic [LB-1:0] k;
  logic [PB-1:0] mask;
  always_comb begin
    if (log2_q < aept_pkg::K_MIN) begin
      k = aept_pkg::K_MIN;
    end else if (log2_q > aept_pkg::K_MAX) begin
      k = aept_pkg::K_MAX;
    end else begin
      k = log2_q;
    end
    mask = ~({PB{1'b1}} << k);
  end

  // turn tracking terms
  logic [PB-1:0] mech;
  logic [PB:0]   delta, quarter;
  logic [TB-1:0] turns_base, turns_d;
  always_comb begin
    mech       = (pos_q - (offset_q & mask)) & mask;
    delta      = {1'b0, pos_q} - {1'b0, last_pos_q};
    quarter    = (PB+1)'(1) << (k - LB'(2));
    turns_base = (cmd_q && !last_cmd_q) ? '0 : turns_q;
    if ($signed(delta) > $signed(quarter)) begin
      turns_d = turns_base - TB'(1);
    end else if ($signed(delta) < -$signed(quarter)) begin
      turns_d = turns_base + TB'(1);
    end else begin
      turns_d = turns_base;
    end
  end

  // multi-turn position and angle scaling
  logic [MB-1:0] multi_d;
  logic [aept_pkg::ANGLE_BITS-1:0] angle_d;
  always_comb begin
    multi_d = ({{(MB-TB){turns_q[TB-1]}}, turns_q} << k) + {{(MB-PB){1'b0}}, pos_q};
    if (k <= aept_pkg::K_ANGLE) begin
      angle_d = aept_pkg::ANGLE_BITS'(prod_e_q << (aept_pkg::K_ANGLE - k));
    end else begin
      angle_d = aept_pkg::ANGLE_BITS'(prod_e_q >> (k - aept_pkg::K_ANGLE));
    end
  end

  // speed scaling terms
  logic [MB:0]   quot;
  logic [PB-1:0] rem;
  logic [32:0]   m_sum;
  logic [32:0]   m_lim;
  logic [SB-1:0] raw_d;
  always_comb begin
    quot  = mag_q >> k;
    rem   = mag_q[PB-1:0] & mask;
    m_sum = {1'b0, prod_q_q} + 33'(prod_r_q >> k);
    if (neg_q) begin
      m_lim = (qsat_q || m_sum > 33'h080000000) ? 33'h080000000 : m_sum;
      raw_d = SB'(~m_lim + 33'd1);
    end else begin
      m_lim = (qsat_q || m_sum > 33'h07FFFFFFF) ? 33'h07FFFFFFF : m_sum;
      raw_d = SB'(m_lim);
    end
  end

  // filter sum, divide by 256 toward zero
  logic signed [40:0] f_sum, f_adj;
  always_comb begin
    f_sum = {{3{p_old_q[37]}}, p_old_q} + {p_raw_q[39], p_raw_q};
    f_adj = f_sum + (f_sum[40] ? 41'sd255 : 41'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q      <= aept_pkg::LOG2_RST;
      offset_q    <= '0;
      poles_q     <= aept_pkg::POLES_RST;
      last_pos_q  <= '0;
      last_cmd_q  <= 1'b0;
      turns_q     <= '0;
      wsp_q       <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          aept_pkg::REG_RES_LOG2: log2_q   <= cfg_data_i[LB-1:0];
          aept_pkg::REG_OFFSET:   offset_q <= cfg_data_i;
          aept_pkg::REG_POLES:    poles_q  <= cfg_data_i[aept_pkg::POLE_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.track) begin
        last_pos_q <= pos_q;
        last_cmd_q <= cmd_q;
        turns_q    <= turns_d;
      end
      if (cmd_i.acc) begin
        speed_q <= f_adj[39:8];
        wsp_q   <= multi_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pos_q  <= in_position_i & mask;
      tick_q <= in_speed_tick_i;
      cmd_q  <= in_turns_reset_i;
    end
    if (cmd_i.track) begin
      prod_e_q <= {8'b0, mech} * {24'b0, poles_q};
    end
    if (cmd_i.multi) begin
      multi_q <= multi_d;
      angle_q <= angle_d;
    end
    if (cmd_i.diff) begin
      diff_q <= {multi_q[MB-1], multi_q} - {wsp_q[MB-1], wsp_q};
    end
    if (cmd_i.absv) begin
      neg_q <= diff_q[MB];
      mag_q <= diff_q[MB] ? (~diff_q + (MB+1)'(1)) : diff_q;
    end
    if (cmd_i.scale) begin
      qsat_q   <= quot > aept_pkg::Q_LAST_OK;
      prod_q_q <= {21'b0, quot[10:0]} * aept_pkg::SPEED_FACTOR;
      prod_r_q <= {21'b0, rem} * {13'b0, aept_pkg::SPEED_FACTOR};
    end
    if (cmd_i.sat) begin
      raw_q <= raw_d;
    end
    if (cmd_i.filt) begin
      p_old_q <= $signed({{6{speed_q[SB-1]}}, speed_q}) * 38'(aept_pkg::FILT_OLD);
      p_raw_q <= $signed({{8{raw_q[SB-1]}}, raw_q}) * 40'(aept_pkg::FILT_NEW);
    end
    if (cmd_i.emit) begin
      out_angle_q <= angle_q;
      out_turns_q <= turns_q;
      out_multi_q <= multi_q;
      out_speed_q <= speed_q;
    end
  end

  assign sts_o.tick     = tick_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_angle_o    = out_angle_q;
  assign out_turns_o    = out_turns_q;
  assign out_multi_o    = out_multi_q;
  assign out_speed_o    = out_speed_q;

  a_pos_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.track |-> ((pos_q & ~mask) == '0))
    else $error("captured position exceeds resolution");

  // a reset edge zeroes the count and a wrap on the same sample moves it one off zero
  a_turn_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.track |=> (turns_q == $past(turns_q) || turns_q == $past(turns_q) + TB'(1) ||
                     turns_q == $past(turns_q) - TB'(1) || turns_q == '0 ||
                     turns_q == TB'(1) || turns_q == '1))
    else $error("turn count moved by more than one");

  a_emit_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (out_valid_q && out_multi_q == $past(multi_q)))
    else $error("output register missed the multi-turn position");

endmodule

`default_nettype wire

// ----- hdl/abs_encoder_position_tracker.sv -----
// Top level of the absolute encoder position tracker.
//
//  channel   dir  beat fields (low bit first)
//  --------  ---  ------------------------------------------------------------
//  s_axis    in   tdata: position[23:0]; tlast: speed_tick; tuser: turns_reset
//  m_axis    out  tdata: electrical_angle[15:0], turn_count[47:16],
//                        multi_position[103:48], speed[135:104]
//  cfg       in   cfg_addr_i: 0 resolution_log2, 1 angle_offset, 2 pole_pairs
//
// A sample passes through accept, track and multi-turn build, then, with a
// speed tick only, six speed steps (difference, magnitude, scaling
// multiplies, saturation, filter multiplies, filter sum) in the sequencer,
// then the load into the output register, which waits for it to be free.
// One sample is in flight at a time; the next beat is taken as soon as the
// result sits in the output register, even while the sink stalls.
// Reset clears turn count, speed, window start and the edge detector, and
// loads the registers with resolution 2^14, offset 0 and 4 pole pairs.
// Config writes are always ready and are meant for idle periods only.
`default_nettype none

module abs_encoder_position_tracker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [23:0]                         s_axis_tdata,  // position
  input  wire logic                                s_axis_tlast,  // speed_tick
  input  wire logic                                s_axis_tuser,  // turns_reset
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // electrical_angle, turn_count, multi_position, speed
  output logic [135:0]                             m_axis_tdata,
  // register writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [aept_pkg::CFG_ADDR_BITS-1:0]  cfg_addr_i,
  input  wire logic [23:0]                         cfg_data_i
);

  aept_pkg::cmd_t cmd;
  aept_pkg::sts_t sts;

  logic [aept_pkg::ANGLE_BITS-1:0] angle;
  logic [aept_pkg::TURN_BITS-1:0]  turns;
  logic [aept_pkg::MULTI_BITS-1:0] multi;
  logic [aept_pkg::SPEED_BITS-1:0] speed;

  assign cfg_ready_o = 1'b1;

  aept_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  aept_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_position_i    (s_axis_tdata),
    .in_speed_tick_i  (s_axis_tlast),
    .in_turns_reset_i (s_axis_tuser),
    .cfg_we_i         (cfg_valid_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_angle_o      (angle),
    .out_turns_o      (turns),
    .out_multi_o      (multi),
    .out_speed_o      (speed)
  );

  assign m_axis_tdata = {speed, multi, turns, angle};

endmodule

`default_nettype wire
